[design/sgd_pkg.sv]
// ----------------------------------------------------------------------------
// sgd_pkg: shared types and constants of the stop/go debouncer
// Table size, field widths, register indexes, function codes and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package sgd_pkg;

  // table and field sizes
  localparam int SLOTS        = 16;
  localparam int SLOT_BITS    = $clog2(SLOTS);
  localparam int CHAN_BITS    = 4;
  localparam int WORD_BITS    = 32;
  localparam int TIME_BITS    = 32;
  localparam int HOLD_BITS    = 24;
  localparam int CFG_IDX_BITS = 2;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_STOP_HOLD = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_GO_HOLD   = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_RETAIN    = 2'd2;

  // item function codes
  localparam logic FUNC_OBSERVE = 1'b0;
  localparam logic FUNC_SWEEP   = 1'b1;

  // confirmed decision codes
  localparam logic [1:0] CONF_NONE = 2'b00;
  localparam logic [1:0] CONF_STOP = 2'b01;
  localparam logic [1:0] CONF_GO   = 2'b10;

  // controller to datapath
  typedef struct packed {
    logic load_in;     // capture the accepted item
    logic rd_sweep;    // read the tables at the sweep index
    logic obs_upd;     // apply the observation and load its result
    logic sweep_eval;  // evaluate the slot at the sweep index
    logic emit_end;    // load the closing result of the sweep
  } sgd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic known;       // captured observation has a known colour
    logic out_free;    // result register can take a result this cycle
    logic report;      // current sweep slot is to be reported
    logic pending;     // a sweep result is held back
    logic last_slot;   // sweep index is at the final slot
  } sgd_stat_t;

endpackage

[design/sgd_if.sv]
// ----------------------------------------------------------------------------
// sgd_obs_if / sgd_res_if: item channels of the stop/go debouncer
// Valid/ready channels carrying observation items and result items.
// ----------------------------------------------------------------------------
interface sgd_obs_if import sgd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 func;
  logic [CHAN_BITS-1:0] channel;
  logic [TIME_BITS-1:0] now_ms;
  logic                 color_known;
  logic                 shows_stop;
  logic [WORD_BITS-1:0] signal_word;

  modport source (output valid, func, channel, now_ms, color_known, shows_stop,
                  signal_word, input ready);
  modport sink (input valid, func, channel, now_ms, color_known, shows_stop,
                signal_word, output ready);
endinterface

interface sgd_res_if import sgd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CHAN_BITS-1:0] out_channel;
  logic [WORD_BITS-1:0] stable_word;
  logic                 present;
  logic                 last;

  modport source (output valid, out_channel, stable_word, present, last,
                  input ready);
  modport sink (input valid, out_channel, stable_word, present, last,
                output ready);
endinterface

[design/sgd_datapath.sv]
// ----------------------------------------------------------------------------
// sgd_datapath: per-slot state, hold timing and result register
// Holds the configuration, the slot flags, the time and word tables, the
// sweep index, the held-back sweep result and the output register.
// ----------------------------------------------------------------------------
module sgd_datapath import sgd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  // configuration
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [HOLD_BITS-1:0]    cfg_data,
  // control
  input  sgd_cmd_t                cmd,
  output sgd_stat_t               stat,
  // input payload
  input  logic                    in_func,
  input  logic [CHAN_BITS-1:0]    in_channel,
  input  logic [TIME_BITS-1:0]    in_now_ms,
  input  logic                    in_color_known,
  input  logic                    in_shows_stop,
  input  logic [WORD_BITS-1:0]    in_signal_word,
  // result
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [CHAN_BITS-1:0]    out_channel,
  output logic [WORD_BITS-1:0]    out_word,
  output logic                    out_present,
  output logic                    out_last
);

  // configuration registers
  logic [HOLD_BITS-1:0] stop_hold;
  logic [HOLD_BITS-1:0] go_hold;
  logic [HOLD_BITS-1:0] retain;

  // captured item
  logic                 func_q;
  logic [SLOT_BITS-1:0] ch_q;
  logic [TIME_BITS-1:0] now_q;
  logic                 known_q;
  logic                 stop_q;
  logic [WORD_BITS-1:0] word_q;

  // slot flags
  logic [SLOTS-1:0] valid;
  logic [SLOTS-1:0] seen;
  logic [SLOTS-1:0] stop_armed;
  logic [SLOTS-1:0] go_armed;
  logic [1:0]       conf [SLOTS];

  // slot tables and their registered read data
  logic [TIME_BITS-1:0] stop_since_mem [SLOTS];
  logic [TIME_BITS-1:0] go_since_mem   [SLOTS];
  logic [WORD_BITS-1:0] stable_mem     [SLOTS];
  logic [TIME_BITS-1:0] last_seen_mem  [SLOTS];
  logic [TIME_BITS-1:0] stop_since_rd;
  logic [TIME_BITS-1:0] go_since_rd;
  logic [WORD_BITS-1:0] stable_rd;
  logic [TIME_BITS-1:0] last_seen_rd;
  logic [SLOT_BITS-1:0] rd_addr;

  // sweep
  logic [SLOT_BITS-1:0] idx;
  logic                 pend_valid;
  logic [SLOT_BITS-1:0] pend_ch;
  logic [WORD_BITS-1:0] pend_word;

  // observation update terms
  logic                 fresh;
  logic                 sa;
  logic                 ga;
  logic [1:0]           cf;
  logic                 first;
  logic [TIME_BITS-1:0] base;
  logic [TIME_BITS-1:0] hold;
  logic [TIME_BITS-1:0] elapsed;
  logic                 hold_met;
  logic [1:0]           cf_next;
  logic                 adopt;
  logic [WORD_BITS-1:0] stable_next;

  // sweep terms
  logic [TIME_BITS-1:0] idle_time;
  logic                 expired;
  logic                 load_out;
  logic                 load_pend;

  // configuration writes, other indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      stop_hold <= '0;
      go_hold   <= '0;
      retain    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STOP_HOLD: stop_hold <= cfg_data;
        REG_GO_HOLD:   go_hold   <= cfg_data;
        REG_RETAIN:    retain    <= cfg_data;
        default: ;
      endcase
    end
  end

  // capture the accepted item
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      func_q  <= in_func;
      ch_q    <= SLOT_BITS'(in_channel);
      now_q   <= in_now_ms;
      known_q <= in_color_known;
      stop_q  <= in_shows_stop;
      word_q  <= in_signal_word;
    end
  end

  // table read: live channel at accept, sweep index during the sweep
  assign rd_addr = cmd.rd_sweep ? idx : SLOT_BITS'(in_channel);

  // read data is held while the item waits on the result register
  always_ff @(posedge clk) begin
    if (cmd.load_in || cmd.rd_sweep) begin
      stop_since_rd <= stop_since_mem[rd_addr];
      go_since_rd   <= go_since_mem[rd_addr];
      stable_rd     <= stable_mem[rd_addr];
      last_seen_rd  <= last_seen_mem[rd_addr];
    end
  end

  // observation: a free slot starts from cleared flags
  always_comb begin
    fresh = !valid[ch_q];
    sa    = !fresh && stop_armed[ch_q];
    ga    = !fresh && go_armed[ch_q];
    cf    = fresh ? CONF_NONE : conf[ch_q];
    first = !sa && !ga;
    // start time is now when the decision is newly armed
    if (stop_q) begin
      base = sa ? stop_since_rd : now_q;
      hold = TIME_BITS'(stop_hold);
    end else begin
      base = ga ? go_since_rd : now_q;
      hold = TIME_BITS'(go_hold);
    end
    elapsed  = now_q - base;
    hold_met = elapsed >= hold;
    cf_next  = cf;
    if (hold_met || first) begin
      cf_next = stop_q ? CONF_STOP : CONF_GO;
    end
    adopt       = stop_q ? cf_next[0] : cf_next[1];
    stable_next = adopt ? word_q : (fresh ? '0 : stable_rd);
  end

  // sweep: expiry of an unobserved slot
  assign idle_time = now_q - last_seen_rd;
  assign expired   = (retain == '0) || (idle_time > TIME_BITS'(retain));
  assign load_pend = cmd.sweep_eval && valid[idx] && !seen[idx] && !expired;
  assign load_out  = cmd.obs_upd || cmd.emit_end || (load_pend && pend_valid);

  // table writes on observation
  always_ff @(posedge clk) begin
    if (cmd.obs_upd) begin
      if (stop_q && !sa) begin
        stop_since_mem[ch_q] <= now_q;
      end
      if (!stop_q && !ga) begin
        go_since_mem[ch_q] <= now_q;
      end
      stable_mem[ch_q]    <= stable_next;
      last_seen_mem[ch_q] <= now_q;
    end
  end

  // slot flags
  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      seen       <= '0;
      stop_armed <= '0;
      go_armed   <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        conf[i] <= CONF_NONE;
      end
    end else if (cmd.obs_upd) begin
      valid[ch_q]      <= 1'b1;
      seen[ch_q]       <= 1'b1;
      stop_armed[ch_q] <= stop_q;
      go_armed[ch_q]   <= !stop_q;
      conf[ch_q]       <= cf_next;
    end else if (cmd.sweep_eval && valid[idx]) begin
      if (seen[idx]) begin
        seen[idx] <= 1'b0;
      end else if (expired) begin
        valid[idx]      <= 1'b0;
        stop_armed[idx] <= 1'b0;
        go_armed[idx]   <= 1'b0;
        conf[idx]       <= CONF_NONE;
      end
    end
  end

  // sweep index and held-back result
  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      pend_valid <= 1'b0;
    end else begin
      if (cmd.load_in || cmd.emit_end) begin
        idx        <= '0;
        pend_valid <= 1'b0;
      end else if (cmd.sweep_eval) begin
        idx <= idx + 1'b1;
        if (load_pend) begin
          pend_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_pend) begin
      pend_ch   <= idx;
      pend_word <= stable_rd;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.obs_upd) begin
      out_channel <= CHAN_BITS'(ch_q);
      out_word    <= stable_next;
      out_present <= 1'b1;
      out_last    <= 1'b1;
    end else if (cmd.emit_end) begin
      out_channel <= pend_valid ? CHAN_BITS'(pend_ch) : '0;
      out_word    <= pend_valid ? pend_word : '0;
      out_present <= pend_valid;
      out_last    <= 1'b1;
    end else if (load_pend && pend_valid) begin
      out_channel <= CHAN_BITS'(pend_ch);
      out_word    <= pend_word;
      out_present <= 1'b1;
      out_last    <= 1'b0;
    end
  end

  // status to the controller
  assign stat.known     = known_q && (func_q == FUNC_OBSERVE);
  assign stat.out_free  = !out_valid || out_ready;
  assign stat.report    = valid[idx] && !seen[idx] && !expired;
  assign stat.pending   = pend_valid;
  assign stat.last_slot = (idx == SLOT_BITS'(SLOTS - 1));

endmodule

[design/sgd_ctrl.sv]
// ----------------------------------------------------------------------------
// sgd_ctrl: sequencing controller of the stop/go debouncer
// Steps an observation through read and update, and a frame end through
// a read and an evaluation per slot followed by the closing result.
// ----------------------------------------------------------------------------
module sgd_ctrl import sgd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_func,
  output logic      in_ready,
  input  sgd_stat_t stat,
  output sgd_cmd_t  cmd
);

  typedef enum logic [2:0] {
    IDLE,
    OBS_UPD,
    SW_RD,
    SW_EVAL,
    SW_END
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_ready = (state == IDLE);
  assign accept   = in_valid && in_ready;

  // command decode and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      IDLE: begin
        if (accept) begin
          cmd.load_in = 1'b1;
          state_next  = (in_func == FUNC_SWEEP) ? SW_RD : OBS_UPD;
        end
      end
      OBS_UPD: begin
        if (!stat.known) begin
          state_next = IDLE;
        end else if (stat.out_free) begin
          cmd.obs_upd = 1'b1;
          state_next  = IDLE;
        end
      end
      SW_RD: begin
        cmd.rd_sweep = 1'b1;
        state_next   = SW_EVAL;
      end
      SW_EVAL: begin
        // a held result goes out first when the next one is found
        if (!(stat.report && stat.pending && !stat.out_free)) begin
          cmd.sweep_eval = 1'b1;
          state_next     = stat.last_slot ? SW_END : SW_RD;
        end
      end
      SW_END: begin
        if (stat.out_free) begin
          cmd.emit_end = 1'b1;
          state_next   = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[design/signal_stop_go_debouncer.sv]
// ----------------------------------------------------------------------------
// signal_stop_go_debouncer: multi-channel stop/go debouncer
// Confirms stop or go per slot after a hold time and reports stable words.
// ----------------------------------------------------------------------------
// Works on one item at a time. An observation reads the slot tables at
// accept and updates them once the result register is free, and gives one
// result; an observation of unknown colour gives none. A frame-end item
// walks the 16 slots, each by a table read and then an evaluation, after
// the accept step and before the closing step, and the next item is taken
// only once it is done; it gives the retained unobserved slots in
// ascending order or a single empty result. A full result register holds
// up either kind of item. Hold and retention times are compared in
// wrapping 32-bit milliseconds; configuration is to be written only
// while no item is in progress, and the block itself does not enforce it.
// ----------------------------------------------------------------------------
module signal_stop_go_debouncer import sgd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [HOLD_BITS-1:0]    cfg_data,
  sgd_obs_if.sink                 obs,
  sgd_res_if.source               res
);

  sgd_cmd_t  cmd;
  sgd_stat_t stat;

  // sequencing
  sgd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (obs.valid),
    .in_func  (obs.func),
    .in_ready (obs.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // slot state and result register
  sgd_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cmd            (cmd),
    .stat           (stat),
    .in_func        (obs.func),
    .in_channel     (obs.channel),
    .in_now_ms      (obs.now_ms),
    .in_color_known (obs.color_known),
    .in_shows_stop  (obs.shows_stop),
    .in_signal_word (obs.signal_word),
    .out_valid      (res.valid),
    .out_ready      (res.ready),
    .out_channel    (res.out_channel),
    .out_word       (res.stable_word),
    .out_present    (res.present),
    .out_last       (res.last)
  );

endmodule

[dv/sgd_debounce_check.sv]
// ----------------------------------------------------------------------------
// sgd_debounce_check: result checker of the stop/go debouncer
// Watches both item channels and the register port, keeps its own copy of
// the slot tables and timing registers, works out the results every accepted
// item must give and compares each result item field by field, in order.
// ----------------------------------------------------------------------------
module sgd_debounce_check import sgd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [HOLD_BITS-1:0]    cfg_data,
  sgd_obs_if                      obs,
  sgd_res_if                      res,
  output int                      errors,
  output int                      pending
);

  typedef struct packed {
    logic [CHAN_BITS-1:0] out_channel;
    logic [WORD_BITS-1:0] stable_word;
    logic                 present;
    logic                 last;
  } report_t;

  // timing registers as last written
  logic [HOLD_BITS-1:0] hold_stop;
  logic [HOLD_BITS-1:0] hold_go;
  logic [HOLD_BITS-1:0] retain;

  // per-slot tables
  logic                 in_use   [SLOTS];
  logic                 seen     [SLOTS];
  logic                 stop_on  [SLOTS];
  logic [TIME_BITS-1:0] stop_t0  [SLOTS];
  logic                 go_on    [SLOTS];
  logic [TIME_BITS-1:0] go_t0    [SLOTS];
  logic [1:0]           decided  [SLOTS];
  logic [WORD_BITS-1:0] held_word[SLOTS];
  logic [TIME_BITS-1:0] seen_at  [SLOTS];

  report_t due_reports[$];
  int      mismatch_count;

  assign errors = mismatch_count;

  // forget everything about one slot
  task automatic free_slot(input int s);
    in_use[s]    = 1'b0;
    seen[s]      = 1'b0;
    stop_on[s]   = 1'b0;
    stop_t0[s]   = '0;
    go_on[s]     = 1'b0;
    go_t0[s]     = '0;
    decided[s]   = CONF_NONE;
    held_word[s] = '0;
    seen_at[s]   = '0;
  endtask

  // stop/go hysteresis of one observation
  task automatic debounce_observation(input logic [CHAN_BITS-1:0] ch,
                                      input logic [TIME_BITS-1:0] now,
                                      input logic known, input logic stop,
                                      input logic [WORD_BITS-1:0] word);
    logic                 first;
    logic [TIME_BITS-1:0] elapsed;
    report_t              r;
    if (!known) return;
    if (!in_use[ch]) begin
      free_slot(ch);
      in_use[ch] = 1'b1;
    end
    first = !stop_on[ch] && !go_on[ch];
    if (stop) begin
      go_on[ch] = 1'b0;
      if (!stop_on[ch]) begin
        stop_on[ch] = 1'b1;
        stop_t0[ch] = now;
      end
      elapsed = now - stop_t0[ch];
      if (elapsed >= TIME_BITS'(hold_stop)) decided[ch] = CONF_STOP;
    end else begin
      stop_on[ch] = 1'b0;
      if (!go_on[ch]) begin
        go_on[ch] = 1'b1;
        go_t0[ch] = now;
      end
      elapsed = now - go_t0[ch];
      if (elapsed >= TIME_BITS'(hold_go)) decided[ch] = CONF_GO;
    end
    // a fresh channel takes its first decision at once
    if (first) decided[ch] = stop ? CONF_STOP : CONF_GO;
    if ((stop && ((decided[ch] & CONF_STOP) != 0)) ||
        (!stop && ((decided[ch] & CONF_GO) != 0)))
      held_word[ch] = word;
    seen_at[ch] = now;
    seen[ch]    = 1'b1;
    r = '{out_channel: ch, stable_word: held_word[ch], present: 1'b1, last: 1'b1};
    due_reports.push_back(r);
  endtask

  // end of frame: report retained unobserved slots, free expired ones
  task automatic sweep_frame(input logic [TIME_BITS-1:0] now);
    int                   n;
    logic [TIME_BITS-1:0] age;
    report_t              prev;
    n = 0;
    prev = '0;
    for (int s = 0; s < SLOTS; s++) begin
      if (!in_use[s]) continue;
      if (seen[s]) begin
        seen[s] = 1'b0;
        continue;
      end
      age = now - seen_at[s];
      if (retain == 0 || age > TIME_BITS'(retain)) begin
        free_slot(s);
      end else if (n < SLOTS) begin
        // hold each report back one slot so the final one can carry last
        if (n > 0) due_reports.push_back(prev);
        prev = '{out_channel: CHAN_BITS'(s), stable_word: held_word[s],
                 present: 1'b1, last: 1'b0};
        n++;
      end
    end
    if (n == 0) begin
      prev = '{out_channel: '0, stable_word: '0, present: 1'b0, last: 1'b1};
    end else begin
      prev.last = 1'b1;
    end
    due_reports.push_back(prev);
  endtask

  task automatic check_field(input string name, input logic [WORD_BITS-1:0] want,
                             input logic [WORD_BITS-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    report_t want;
    if (rst) begin
      hold_stop = '0;
      hold_go   = '0;
      retain    = '0;
      for (int s = 0; s < SLOTS; s++) free_slot(s);
      due_reports.delete();
      mismatch_count = 0;
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_STOP_HOLD: hold_stop = cfg_data;
          REG_GO_HOLD:   hold_go   = cfg_data;
          REG_RETAIN:    retain    = cfg_data;
          default: ;
        endcase
      end
      // result items against the oldest expectation
      if (res.valid && res.ready) begin
        if (due_reports.size() == 0) begin
          $display("%0t: unexpected result item channel %0h word %0h present %0b last %0b",
                   $time, res.out_channel, res.stable_word, res.present, res.last);
          mismatch_count++;
        end else begin
          want = due_reports.pop_front();
          check_field("out_channel", WORD_BITS'(want.out_channel),
                      WORD_BITS'(res.out_channel));
          check_field("stable_word", want.stable_word, res.stable_word);
          check_field("present", WORD_BITS'(want.present), WORD_BITS'(res.present));
          check_field("last", WORD_BITS'(want.last), WORD_BITS'(res.last));
        end
      end
      // accepted input items
      if (obs.valid && obs.ready) begin
        if (obs.func == FUNC_OBSERVE)
          debounce_observation(obs.channel, obs.now_ms, obs.color_known,
                               obs.shows_stop, obs.signal_word);
        else
          sweep_frame(obs.now_ms);
      end
    end
    pending <= due_reports.size();
  end

endmodule

[dv/tb_signal_stop_go_debouncer.sv]
// ----------------------------------------------------------------------------
// tb_signal_stop_go_debouncer: testbench of the stop/go debouncer
// Drives observation and frame-end items with random gaps and result
// back-pressure, reprograms the hold and retention times between phases
// and takes its verdict from the checker that sits beside the block.
// ----------------------------------------------------------------------------
module tb_signal_stop_go_debouncer;
  import sgd_pkg::*;

  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;
  localparam logic [HOLD_BITS-1:0]    HOLD_MAX   = {HOLD_BITS{1'b1}};
  localparam int SETTLE_CYCLES = 40;
  localparam int QUIET_LIMIT   = 4000;

  logic                    clk;
  logic                    rst;
  logic                    cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [HOLD_BITS-1:0]    cfg_data;
  int                      errors;
  int                      pending;
  bit                      idle_en;
  int                      stall_left;
  int                      quiet;
  bit                      stop_state[SLOTS];

  sgd_obs_if obs_ch ();
  sgd_res_if res_ch ();

  signal_stop_go_debouncer u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .obs       (obs_ch),
    .res       (res_ch)
  );

  sgd_debounce_check u_check (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .obs       (obs_ch),
    .res       (res_ch),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // result back-pressure in bursts of random length
  initial begin
    res_ch.ready = 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left != 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 7);
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if ((obs_ch.valid && obs_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // offer one item and wait for its acceptance
  task automatic send_item(input logic f, input logic [CHAN_BITS-1:0] ch,
                           input logic [TIME_BITS-1:0] now, input logic known,
                           input logic stop, input logic [WORD_BITS-1:0] word);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      obs_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    obs_ch.valid       <= 1'b1;
    obs_ch.func        <= f;
    obs_ch.channel     <= ch;
    obs_ch.now_ms      <= now;
    obs_ch.color_known <= known;
    obs_ch.shows_stop  <= stop;
    obs_ch.signal_word <= word;
    @(posedge clk);
    while (!obs_ch.ready) @(posedge clk);
  endtask

  task automatic observe(input logic [CHAN_BITS-1:0] ch, input logic [TIME_BITS-1:0] now,
                         input logic stop, input logic [WORD_BITS-1:0] word);
    send_item(FUNC_OBSERVE, ch, now, 1'b1, stop, word);
  endtask

  // frame end; the other fields carry noise
  task automatic sweep(input logic [TIME_BITS-1:0] now);
    send_item(FUNC_SWEEP, CHAN_BITS'($urandom_range(0, 15)), now, 1'($urandom),
              1'($urandom), $urandom);
  endtask

  // let every expected result drain and the block fall idle
  task automatic wait_quiet();
    obs_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_timing(input logic [HOLD_BITS-1:0] stop_hold,
                             input logic [HOLD_BITS-1:0] go_hold,
                             input logic [HOLD_BITS-1:0] retain);
    cfg_we    <= 1'b1;
    cfg_index <= REG_STOP_HOLD;
    cfg_data  <= stop_hold;
    @(posedge clk);
    cfg_index <= REG_GO_HOLD;
    cfg_data  <= go_hold;
    @(posedge clk);
    cfg_index <= REG_RETAIN;
    cfg_data  <= retain;
    @(posedge clk);
    // an index with no register behind it must change nothing
    cfg_index <= REG_UNUSED;
    cfg_data  <= HOLD_BITS'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // random frames: up to five observations then a frame end
  task automatic run_frames(input int items, input bit quiet_run);
    logic [TIME_BITS-1:0] t;
    logic [TIME_BITS-1:0] when;
    logic [CHAN_BITS-1:0] ch;
    logic                 known;
    int                   count;
    int                   nobs;
    t = $urandom;
    count = 0;
    while (count < items) begin
      idle_en = quiet_run ? 1'b0 : ($urandom_range(0, 2) != 0);
      if ($urandom_range(0, 9) == 0) t += $urandom_range(0, 3000);
      else t += $urandom_range(0, 20);
      nobs = $urandom_range(0, 5);
      for (int k = 0; k < nobs; k++) begin
        ch = CHAN_BITS'($urandom_range(0, 15));
        if ($urandom_range(0, 3) == 0) stop_state[ch] = ~stop_state[ch];
        known = ($urandom_range(0, 7) != 0);
        // now and then an observation stamped off the frame time
        when = ($urandom_range(0, 11) == 0) ? $urandom : t;
        send_item(FUNC_OBSERVE, ch, when, known, stop_state[ch], $urandom);
        if (known) count++;
      end
      sweep(t);
      count++;
    end
  endtask

  initial begin
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_data           = '0;
    obs_ch.valid       = 1'b0;
    obs_ch.func        = FUNC_OBSERVE;
    obs_ch.channel     = '0;
    obs_ch.now_ms      = '0;
    obs_ch.color_known = 1'b0;
    obs_ch.shows_stop  = 1'b0;
    obs_ch.signal_word = '0;
    idle_en            = 1'b1;
    for (int s = 0; s < SLOTS; s++) stop_state[s] = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: hysteresis, repeats, retention edges, empty sweeps
    load_timing(24'd5, 24'd10, 24'd100);
    observe(4'd0, 32'd1000, 1'b1, 32'h0000_0000);
    observe(4'd0, 32'd1003, 1'b0, 32'hA5A5_A5A5);
    observe(4'd0, 32'd1013, 1'b0, 32'h1234_5678);
    send_item(FUNC_OBSERVE, 4'd5, 32'd1013, 1'b0, 1'b1, 32'hDEAD_BEEF);
    observe(4'd15, 32'd1013, 1'b0, 32'hFFFF_FFFF);
    observe(4'd0, 32'd1013, 1'b0, 32'h0F0F_0F0F);
    sweep(32'd1013);
    sweep(32'd1050);
    sweep(32'd1113);
    sweep(32'd1114);
    sweep(32'd1114);
    // hold timing across the wrap of the millisecond counter
    observe(4'd3, 32'hFFFF_FFFE, 1'b0, 32'h5555_5555);
    observe(4'd3, 32'h0000_0002, 1'b1, 32'hAAAA_AAAA);
    observe(4'd3, 32'h0000_0006, 1'b1, 32'h0000_0001);
    observe(4'd3, 32'h0000_0007, 1'b1, 32'h8000_0000);
    observe(4'd3, 32'h0000_000C, 1'b0, 32'h7FFF_FFFF);
    sweep(32'h0000_0020);
    sweep(32'h0000_0020);
    wait_quiet();

    // zero holds and zero retention: unobserved entries go at once
    load_timing('0, '0, '0);
    observe(4'd7, 32'hFFFF_FFFF, 1'b1, 32'hCAFE_0007);
    sweep(32'hFFFF_FFFF);
    sweep(32'h0000_0000);
    run_frames(60, 1'b0);
    wait_quiet();

    // widest holds and retention: a full table gives sixteen results
    load_timing(HOLD_MAX, HOLD_MAX, HOLD_MAX);
    for (int s = 0; s < SLOTS; s++) observe(CHAN_BITS'(s), 32'h8000_0000, 1'($urandom),
                                            $urandom);
    sweep(32'h8000_0000);
    sweep(32'h80FF_FFFF);
    run_frames(60, 1'b0);
    wait_quiet();

    load_timing(HOLD_BITS'($urandom_range(0, 60)), HOLD_BITS'($urandom_range(0, 60)),
                HOLD_BITS'($urandom_range(0, 200)));
    run_frames(120, 1'b0);
    wait_quiet();

    // closing stretch with no idling on either side
    idle_en = 1'b0;
    load_timing(HOLD_BITS'($urandom_range(0, 40)), HOLD_BITS'($urandom_range(0, 40)),
                HOLD_BITS'($urandom_range(1, 120)));
    run_frames(130, 1'b1);
    wait_quiet();

    if (errors == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
